// ===== hdl/ppid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppid_pkg
// Shared types and constants of the positional PID core: widths, codes,
// sequencer states and the request bundles of the iterative units.
// ----------------------------------------------------------------------------
package ppid_pkg;

    localparam int DATA_W   = 32;   // Q16.16 word
    localparam int LIM_W    = 31;   // unsigned limit registers
    localparam int SUM_W    = 48;   // error accumulator, Q32.16
    localparam int MAG_W    = 48;   // multiplier second operand
    localparam int CHUNK_W  = 16;   // multiplier digit
    localparam int PROD_W   = DATA_W + MAG_W;
    localparam int MUL_STEPS = MAG_W / CHUNK_W;
    localparam int MCNT_W   = $clog2(MUL_STEPS + 1);
    localparam int DVD_W    = LIM_W + 16; // integral_limit << 16
    localparam int DCNT_W   = $clog2(DVD_W + 1);
    localparam int TOT_W    = 50;   // P + I + D before the output clamp
    localparam int IDX_W    = 3;

    // opcodes
    localparam logic [1:0] OP_MEAS      = 2'd0;
    localparam logic [1:0] OP_MEAS_RATE = 2'd1;
    localparam logic [1:0] OP_ERR       = 2'd2;
    localparam logic [1:0] OP_ERR_RATE  = 2'd3;

    // result status
    localparam logic [1:0] ST_NORMAL   = 2'd0;
    localparam logic [1:0] ST_CLAMPED  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_TARGET    = 3'd0;
    localparam logic [IDX_W-1:0] REG_GAIN_P    = 3'd1;
    localparam logic [IDX_W-1:0] REG_GAIN_I    = 3'd2;
    localparam logic [IDX_W-1:0] REG_GAIN_D    = 3'd3;
    localparam logic [IDX_W-1:0] REG_OUT_LIM   = 3'd4;
    localparam logic [IDX_W-1:0] REG_INT_LIM   = 3'd5;
    localparam logic [IDX_W-1:0] REG_AUTO_RST  = 3'd6;
    localparam logic [IDX_W-1:0] REG_INT_CLAMP = 3'd7;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_SUM,
        S_IMUL,
        S_IWAIT,
        S_CLAMP,
        S_DIV,
        S_DMUL,
        S_DWAIT,
        S_PMUL,
        S_PWAIT,
        S_ADD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic               start;
        logic [DATA_W-1:0]  a;
        logic [MAG_W-1:0]   b;
    } t_mul_req;

    typedef struct packed {
        logic               start;
        logic [DVD_W-1:0]   dividend;
        logic [DATA_W-1:0]  divisor;
    } t_div_req;

endpackage

// ===== hdl/ppid_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppid_mul
// Iterative unsigned multiplier: 32 bits by 48 bits, one 16-bit digit of
// the second operand per cycle, most significant digit first.
// ----------------------------------------------------------------------------
module ppid_mul import ppid_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mul_req          i_req,
    output logic              o_done,
    output logic [PROD_W-1:0] o_prod
);

    logic [MCNT_W-1:0]         r_cnt;
    logic                      r_done;
    logic [DATA_W-1:0]         r_a;
    logic [MAG_W-1:0]          r_b;
    logic [PROD_W-1:0]         r_acc;
    logic [DATA_W+CHUNK_W-1:0] w_part;

    assign w_part = r_a * r_b[MAG_W-1 -: CHUNK_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == MCNT_W'(1));
            if (i_req.start) begin
                r_cnt <= MCNT_W'(MUL_STEPS);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - MCNT_W'(1);
            end
        end
    end

    // shift the partial sum up one digit and add the next digit product
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_acc <= '0;
        end else if (r_cnt != '0) begin
            r_b   <= {r_b[MAG_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
            r_acc <= {r_acc[PROD_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}}
                     + {{(PROD_W-DATA_W-CHUNK_W){1'b0}}, w_part};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== hdl/ppid_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppid_div
// Restoring divider, one quotient bit per cycle, for the integral
// back-calculation (integral_limit << 16) / |gain_i|.
// ----------------------------------------------------------------------------
module ppid_div import ppid_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quo
);

    logic [DCNT_W-1:0] r_cnt;
    logic              r_done;
    logic [DATA_W-1:0] r_dvs;
    logic [DATA_W-1:0] r_rem;
    logic [DVD_W-1:0]  r_quo;
    logic [DATA_W:0]   w_shift;
    logic [DATA_W+1:0] w_trial;

    assign w_shift = {r_rem, r_quo[DVD_W-1]};
    assign w_trial = {1'b0, w_shift} - {2'b00, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == DCNT_W'(1));
            if (i_req.start) begin
                r_cnt <= DCNT_W'(DVD_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - DCNT_W'(1);
            end
        end
    end

    // keep the trial difference when it does not borrow
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvs <= i_req.divisor;
            r_rem <= '0;
            r_quo <= i_req.dividend;
        end else if (r_cnt != '0) begin
            if (!w_trial[DATA_W+1]) begin
                r_rem <= w_trial[DATA_W-1:0];
                r_quo <= {r_quo[DVD_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[DATA_W-1:0];
                r_quo <= {r_quo[DVD_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== hdl/position_pid_antiwindup_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// position_pid_antiwindup_core
// Positional PID step in Q16.16 with integral auto-reset, integral clamp
// with accumulator back-calculation and a symmetric output clamp.
// ----------------------------------------------------------------------------
// Usage:
//  - Write the eight registers through i_cfg_* while no item is in flight;
//    o_cfg_ready is always high. Index order: target, Kp, Ki, Kd, output
//    limit, integral limit, auto-reset enable, integral clamp enable.
//  - Input beat: s_axis_tuser = opcode, s_axis_tdata = {rate, sample}.
//    Output beat: m_axis_tdata = drive, m_axis_tuser = status.
//  - One item at a time. After the accepting edge the sequencer steps
//    through error, sum, the I product, clamp, the D product, the P
//    product, add and output; the products I, D and P run one after the
//    other on a single 16-bit-digit multiplier. A triggered integral clamp
//    adds a divider pass after the clamp. A new beat is taken only once
//    the sequencer is back in idle.
//  - s_axis_tready is high only while the sequencer is idle, so a new
//    item can be taken while the previous result still waits at the output.
//  - If the receiver stalls, the result holds in the output register and
//    the sequencer waits in its final state with the next result.
//  - Reset (i_rst_n low, synchronous) restores register defaults and
//    clears the accumulator, last error and reset direction.
// ----------------------------------------------------------------------------
module position_pid_antiwindup_core import ppid_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [DATA_W-1:0] i_cfg_data,
    // input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [63:0]       s_axis_tdata,  // [31:0] sample, [63:32] rate
    input  logic [1:0]        s_axis_tuser,  // [1:0] opcode
    // output stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,  // [31:0] drive
    output logic [1:0]        m_axis_tuser   // [1:0] status
);

    // configuration registers
    logic signed [DATA_W-1:0] r_target, r_gp, r_gi, r_gd;
    logic [LIM_W-1:0]         r_olim, r_ilim;
    logic                     r_auto, r_clamp;

    // controller state carried between items
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [DATA_W-1:0] r_last;
    logic                     r_dir;

    // per-item working registers
    t_state                   r_state, n_state;
    logic [1:0]               r_op;
    logic signed [DATA_W-1:0] r_sample, r_rate, r_e;
    logic signed [DATA_W:0]   r_diff;
    logic signed [SUM_W-1:0]  r_iterm;
    logic                     r_iovf;
    logic                     r_qneg;
    logic signed [TOT_W-1:0]  r_d, r_p, r_tot;

    // output register
    logic                     r_out_valid;
    logic [DATA_W-1:0]        r_drive;
    logic [1:0]               r_status;

    // unit handshakes
    t_mul_req                 w_mul_req;
    t_div_req                 w_div_req;
    logic                     w_mul_done, w_div_done;
    logic [PROD_W-1:0]        w_prod;
    logic [DVD_W-1:0]         w_quo;
    logic                     w_out_load;

    // ------------------------------------------------------------------
    // error and accumulator arithmetic
    // ------------------------------------------------------------------
    logic                     w_given, w_ext;
    logic signed [DATA_W:0]   w_edif;
    logic signed [DATA_W-1:0] w_e;
    logic signed [SUM_W:0]    w_sadd;
    logic signed [SUM_W-1:0]  w_ssat;
    logic                     w_epos;

    assign w_given = r_op inside {OP_ERR, OP_ERR_RATE};
    assign w_ext   = r_op inside {OP_MEAS_RATE, OP_ERR_RATE};

    assign w_edif = {r_target[DATA_W-1], r_target} - {r_sample[DATA_W-1], r_sample};

    always_comb begin
        if (w_given) begin
            w_e = r_sample;
        end else if (w_edif[DATA_W] != w_edif[DATA_W-1]) begin
            // saturate the setpoint difference to 32 bits
            w_e = w_edif[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                 : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            w_e = w_edif[DATA_W-1:0];
        end
    end

    assign w_sadd = {r_sum[SUM_W-1], r_sum} + {{(SUM_W-DATA_W+1){r_e[DATA_W-1]}}, r_e};

    always_comb begin
        if (w_sadd[SUM_W] != w_sadd[SUM_W-1]) begin
            w_ssat = w_sadd[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                   : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            w_ssat = w_sadd[SUM_W-1:0];
        end
    end

    assign w_epos = !r_e[DATA_W-1] && (r_e != '0);

    // ------------------------------------------------------------------
    // multiplier operands and product sign
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] w_mag_gi, w_mag_gd, w_mag_gp, w_mag_rate, w_mag_e;
    logic [SUM_W-1:0]  w_mag_sum;
    logic [DATA_W:0]   w_mag_diff;
    logic [MAG_W-1:0]  w_d_b;
    logic              w_ineg, w_dneg, w_pneg;

    assign w_mag_gi   = r_gi[DATA_W-1]     ? DATA_W'(-r_gi)     : DATA_W'(r_gi);
    assign w_mag_gd   = r_gd[DATA_W-1]     ? DATA_W'(-r_gd)     : DATA_W'(r_gd);
    assign w_mag_gp   = r_gp[DATA_W-1]     ? DATA_W'(-r_gp)     : DATA_W'(r_gp);
    assign w_mag_rate = r_rate[DATA_W-1]   ? DATA_W'(-r_rate)   : DATA_W'(r_rate);
    assign w_mag_e    = r_e[DATA_W-1]      ? DATA_W'(-r_e)      : DATA_W'(r_e);
    assign w_mag_sum  = r_sum[SUM_W-1]     ? SUM_W'(-r_sum)     : SUM_W'(r_sum);
    assign w_mag_diff = r_diff[DATA_W]     ? (DATA_W+1)'(-r_diff) : (DATA_W+1)'(r_diff);

    assign w_d_b = w_ext ? {{(MAG_W-DATA_W){1'b0}}, w_mag_rate}
                         : {{(MAG_W-DATA_W-1){1'b0}}, w_mag_diff};

    assign w_ineg = r_gi[DATA_W-1] ^ r_sum[SUM_W-1];
    assign w_dneg = r_gd[DATA_W-1] ^ (w_ext ? r_rate[DATA_W-1] : r_diff[DATA_W]);
    assign w_pneg = r_gp[DATA_W-1] ^ r_e[DATA_W-1];

    // product >> 16; I overflows at 2^47, D and P fit in 48 bits
    logic [SUM_W-2:0]        w_imag;
    logic                    w_iovf;
    logic signed [TOT_W-1:0] w_pq, w_pq_neg;

    assign w_imag   = w_prod[SUM_W+15-1:16];
    assign w_iovf   = |w_prod[PROD_W-1:SUM_W+15];
    assign w_pq     = {{(TOT_W-MAG_W){1'b0}}, w_prod[MAG_W+15:16]};
    assign w_pq_neg = -w_pq;

    // ------------------------------------------------------------------
    // integral clamp decision
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] w_ilim_pos, w_ilim_neg;
    logic                    w_izero, w_ihi, w_ilo, w_div_go;

    assign w_ilim_pos = {{(SUM_W-LIM_W){1'b0}}, r_ilim};
    assign w_ilim_neg = -w_ilim_pos;
    assign w_izero    = (r_iterm == '0);
    assign w_ihi      = r_iterm > w_ilim_pos;
    assign w_ilo      = r_iterm < w_ilim_neg;
    assign w_div_go   = r_clamp && !r_iovf && !w_izero && (w_ihi || w_ilo);

    // ------------------------------------------------------------------
    // output sum and clamp
    // ------------------------------------------------------------------
    logic signed [TOT_W-1:0] w_total, w_olim_pos, w_olim_neg;
    logic [DATA_W-1:0]       w_drive;
    logic [1:0]              w_status;

    assign w_total    = r_tot + {{(TOT_W-SUM_W){r_iterm[SUM_W-1]}}, r_iterm};
    assign w_olim_pos = {{(TOT_W-LIM_W){1'b0}}, r_olim};
    assign w_olim_neg = -w_olim_pos;

    always_comb begin
        if (r_iovf) begin
            w_drive  = '0;
            w_status = ST_OVERFLOW;
        end else if (w_total > w_olim_pos) begin
            w_drive  = w_olim_pos[DATA_W-1:0];
            w_status = ST_CLAMPED;
        end else if (w_total < w_olim_neg) begin
            w_drive  = w_olim_neg[DATA_W-1:0];
            w_status = ST_CLAMPED;
        end else begin
            w_drive  = w_total[DATA_W-1:0];
            w_status = ST_NORMAL;
        end
    end

    // ------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (s_axis_tvalid) n_state = S_ERR;
            S_ERR:   n_state = S_SUM;
            S_SUM:   n_state = S_IMUL;
            S_IMUL:  n_state = S_IWAIT;
            S_IWAIT: if (w_mul_done) n_state = S_CLAMP;
            S_CLAMP: n_state = w_div_go ? S_DIV : S_DMUL;
            S_DIV:   if (w_div_done) n_state = S_DMUL;
            S_DMUL:  n_state = S_DWAIT;
            S_DWAIT: if (w_mul_done) n_state = S_PMUL;
            S_PMUL:  n_state = S_PWAIT;
            S_PWAIT: if (w_mul_done) n_state = S_ADD;
            S_ADD:   n_state = S_OUT;
            S_OUT:   if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer: outputs to the units and the handshakes
    // ------------------------------------------------------------------
    always_comb begin
        s_axis_tready      = 1'b0;
        w_out_load         = 1'b0;
        w_mul_req.start    = 1'b0;
        w_mul_req.a        = w_mag_gi;
        w_mul_req.b        = w_mag_sum;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = {r_ilim, 16'h0000};
        w_div_req.divisor  = w_mag_gi;
        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
            end
            S_IMUL: begin
                w_mul_req.start = 1'b1;
            end
            S_CLAMP: begin
                w_div_req.start = w_div_go;
            end
            S_DMUL, S_DWAIT: begin
                w_mul_req.start = (r_state == S_DMUL);
                w_mul_req.a     = w_mag_gd;
                w_mul_req.b     = w_d_b;
            end
            S_PMUL, S_PWAIT: begin
                w_mul_req.start = (r_state == S_PMUL);
                w_mul_req.a     = w_mag_gp;
                w_mul_req.b     = {{(MAG_W-DATA_W){1'b0}}, w_mag_e};
            end
            S_OUT: begin
                w_out_load = !r_out_valid || m_axis_tready;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // control and carried state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_target    <= '0;
            r_gp        <= '0;
            r_gi        <= '0;
            r_gd        <= '0;
            r_olim      <= '1;
            r_ilim      <= '1;
            r_auto      <= 1'b0;
            r_clamp     <= 1'b0;
            r_sum       <= '0;
            r_last      <= '0;
            r_dir       <= 1'b0;
        end else begin
            r_state <= n_state;

            // hold the result until the receiver takes the beat
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_TARGET:    r_target <= i_cfg_data;
                    REG_GAIN_P:    r_gp     <= i_cfg_data;
                    REG_GAIN_I:    r_gi     <= i_cfg_data;
                    REG_GAIN_D:    r_gd     <= i_cfg_data;
                    REG_OUT_LIM:   r_olim   <= i_cfg_data[LIM_W-1:0];
                    REG_INT_LIM:   r_ilim   <= i_cfg_data[LIM_W-1:0];
                    REG_AUTO_RST:  r_auto   <= i_cfg_data[0];
                    REG_INT_CLAMP: r_clamp  <= i_cfg_data[0];
                    default:       r_auto   <= r_auto;
                endcase
            end

            case (r_state)
                S_SUM: begin
                    r_last <= r_e;
                    // with auto-reset enabled, clear the accumulator when the error changes sign
                    if (r_auto && w_epos && !r_dir) begin
                        r_sum <= '0;
                        r_dir <= 1'b1;
                    end else if (r_auto && r_e[DATA_W-1] && r_dir) begin
                        r_sum <= '0;
                        r_dir <= 1'b0;
                    end else begin
                        r_sum <= w_ssat;
                    end
                end
                S_CLAMP: begin
                    if (r_clamp && (r_iovf || w_izero)) begin
                        r_sum <= '0;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_sum <= r_qneg ? -SUM_W'(w_quo) : SUM_W'(w_quo);
                    end
                end
                default: begin
                    r_dir <= r_dir;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // per-item datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_op     <= s_axis_tuser;
                r_sample <= s_axis_tdata[DATA_W-1:0];
                r_rate   <= s_axis_tdata[2*DATA_W-1:DATA_W];
            end
            S_ERR: begin
                r_e <= w_e;
            end
            S_SUM: begin
                r_diff <= {r_e[DATA_W-1], r_e} - {r_last[DATA_W-1], r_last};
            end
            S_IWAIT: begin
                r_iovf  <= w_iovf;
                r_iterm <= w_ineg ? -{1'b0, w_imag} : {1'b0, w_imag};
            end
            S_CLAMP: begin
                if (r_clamp) begin
                    if (r_iovf || w_izero) begin
                        r_iterm <= '0;
                        r_iovf  <= 1'b0;
                    end else if (w_ihi) begin
                        r_iterm <= w_ilim_pos;
                        r_qneg  <= r_gi[DATA_W-1];
                    end else if (w_ilo) begin
                        r_iterm <= w_ilim_neg;
                        r_qneg  <= !r_gi[DATA_W-1];
                    end
                end
            end
            S_DWAIT: begin
                r_d <= w_dneg ? w_pq_neg : w_pq;
            end
            S_PWAIT: begin
                r_p <= w_pneg ? w_pq_neg : w_pq;
            end
            S_ADD: begin
                r_tot <= r_p + r_d;
            end
            default: begin
                r_tot <= r_tot;
            end
        endcase

        if (w_out_load) begin
            r_drive  <= w_drive;
            r_status <= w_status;
        end
    end

    // ------------------------------------------------------------------
    // iterative units
    // ------------------------------------------------------------------
    ppid_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    ppid_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_drive;
    assign m_axis_tuser  = r_status;

endmodule
